### rtl/core/mbpf_pkg.sv
`timescale 1ns / 1ps

package mbpf_pkg;

	// Configuration channel
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	// Fixed field widths
	localparam int LEN_W        = 5;
	localparam int OCC_W        = 16;
	localparam int CARE_W       = 16;
	localparam int OUT_OFFSET_W = 32;
	localparam int PATTERN_W    = 128;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PATTERN_LOW      = 3'd0,
		CFG_PATTERN_HIGH     = 3'd1,
		CFG_CARE_MASK        = 3'd2,
		CFG_PATTERN_LENGTH   = 3'd3,
		CFG_OCCURRENCE_INDEX = 3'd4
	} cfg_reg_t;

endpackage

### rtl/core/mbpf_ifs.sv
`timescale 1ns / 1ps

// Byte stream channel
interface mbpf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface

// Search result channel
interface mbpf_result_if;
	logic                               valid;
	logic                               ready;
	logic                               found;
	logic [mbpf_pkg::OUT_OFFSET_W-1:0]  match_offset;

	modport source (output valid, output found, output match_offset, input ready);
	modport sink (input valid, input found, input match_offset, output ready);
endinterface

// Register write channel
interface mbpf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [mbpf_pkg::CFG_INDEX_W-1:0]  index;
	logic [mbpf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/masked_byte_pattern_finder_core.sv
`timescale 1ns / 1ps

// Masked byte pattern finder.
// Channels: "data" carries one region byte per transfer with first/last marks,
// "result" carries at most one transfer per region (found + match_offset), and
// "cfg" writes the pattern, care mask, length and occurrence registers (always
// ready; write only while the block is idle).
// Each accepted byte is shifted into a window of the newest MAX_PATTERN bytes and
// compared, in parallel, against the masked pattern in the same cycle; a result
// is registered on that edge into the output register, or into the skid entry
// when a stalled receiver holds the output register. Throughput is one byte per
// cycle while the skid entry is free, set by the window compare and counter update.
// The requested occurrence gives found=1 with the start offset; a region that ends
// without it gives found=0, offset 0, on its last byte. Once a region has its
// result, bytes up to the next first_byte are dropped.
// Reset clears the window, counters and output buffer and loads the register
// defaults (care mask all ones, length 1, occurrence 0).
// A stalled receiver is absorbed by an output register plus one skid entry; byte
// input is only held off while the skid entry is occupied.
module masked_byte_pattern_finder_core #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mbpf_byte_if.sink            data,
	mbpf_result_if.source        result,
	mbpf_cfg_if.sink             cfg
);

	localparam int LEN_W = mbpf_pkg::LEN_W;
	localparam int OUT_W = mbpf_pkg::OUT_OFFSET_W;

	// configuration registers
	logic [63:0]                  pat_low_q;
	logic [63:0]                  pat_high_q;
	logic [mbpf_pkg::CARE_W-1:0]  care_q;
	logic [LEN_W-1:0]             pat_len_q;
	logic [mbpf_pkg::OCC_W-1:0]   occ_q;

	// region state
	logic [7:0]                   win_q [MAX_PATTERN];
	logic [OFFSET_BITS-1:0]       seen_q;
	logic [mbpf_pkg::OCC_W-1:0]   matches_q;
	logic                         done_q;

	// output register and skid entry
	logic                         out_valid_q;
	logic                         out_found_q;
	logic [OUT_W-1:0]             out_offset_q;
	logic                         skid_valid_q;
	logic                         skid_found_q;
	logic [OUT_W-1:0]             skid_offset_q;

	logic [mbpf_pkg::PATTERN_W-1:0] pattern;
	logic [LEN_W-1:0]             len_used;
	logic [7:0]                   win_n [MAX_PATTERN];
	logic [7:0]                   got;
	logic                         win_match;
	logic                         accept;
	logic                         live;
	logic [OFFSET_BITS-1:0]       seen_eff;
	logic [OFFSET_BITS-1:0]       seen_n;
	logic [OFFSET_BITS-1:0]       start_pos;
	logic [OFFSET_BITS+OUT_W-1:0] start_ext;
	logic [mbpf_pkg::OCC_W-1:0]   matches_eff;
	logic [mbpf_pkg::OCC_W-1:0]   matches_n;
	logic [mbpf_pkg::OCC_W-1:0]   target;
	logic                         hit;
	logic                         found_hit;
	logic                         res_valid;
	logic [OUT_W-1:0]             res_offset;
	logic                         out_free;

	assign cfg.ready = 1'b1;

	assign pattern = {pat_high_q, pat_low_q};

	// length 0 acts as 1, over-long clamps to the window size
	always_comb begin
		if (pat_len_q == '0) begin
			len_used = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(MAX_PATTERN)) begin
			len_used = LEN_W'(MAX_PATTERN);
		end else begin
			len_used = pat_len_q;
		end
	end

	assign accept = data.valid && data.ready;

	// a first byte starts from a cleared window and cleared counts
	assign seen_eff    = data.first_byte ? '0 : seen_q;
	assign matches_eff = data.first_byte ? '0 : matches_q;
	assign live        = data.first_byte || !done_q;

	always_comb begin
		win_n[0] = data.data_byte;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_n[k] = data.first_byte ? 8'd0 : win_q[k-1];
		end
	end

	// saturating byte count
	assign seen_n = (seen_eff == '1) ? seen_eff : seen_eff + OFFSET_BITS'(1);

	// pattern byte i lines up with window entry len-1-i (entry 0 newest)
	always_comb begin
		win_match = 1'b1;
		got       = 8'd0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			got = 8'd0;
			for (int j = 0; j < MAX_PATTERN; j++) begin
				if (LEN_W'(j) == len_used - LEN_W'(i) - LEN_W'(1)) begin
					got = win_n[j];
				end
			end
			if (LEN_W'(i) < len_used && care_q[i] && got != pattern[8*i +: 8]) begin
				win_match = 1'b0;
			end
		end
	end

	// only matches that lie wholly within the region count
	assign hit       = live && (seen_n >= OFFSET_BITS'(len_used)) && win_match;
	assign matches_n = (hit && matches_eff != '1) ? matches_eff + mbpf_pkg::OCC_W'(1)
		: matches_eff;
	assign target    = (occ_q == '0) ? mbpf_pkg::OCC_W'(1) : occ_q;
	assign found_hit = hit && (matches_n == target);
	assign res_valid = accept && live && (found_hit || data.last_byte);

	assign start_pos  = seen_n - OFFSET_BITS'(len_used);
	assign start_ext  = {{OUT_W{1'b0}}, start_pos};
	assign res_offset = found_hit ? start_ext[OUT_W-1:0] : '0;

	// input held off only while a result sits in the skid entry
	assign data.ready = !skid_valid_q;
	assign out_free   = !out_valid_q || result.ready;

	assign result.valid        = out_valid_q;
	assign result.found        = out_found_q;
	assign result.match_offset = out_offset_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '1;
			pat_len_q  <= LEN_W'(1);
			occ_q      <= '0;
		end else if (cfg.valid) begin
			unique case (mbpf_pkg::cfg_reg_t'(cfg.index))
				mbpf_pkg::CFG_PATTERN_LOW: begin
					pat_low_q <= cfg.data;
				end
				mbpf_pkg::CFG_PATTERN_HIGH: begin
					pat_high_q <= cfg.data;
				end
				mbpf_pkg::CFG_CARE_MASK: begin
					care_q <= cfg.data[mbpf_pkg::CARE_W-1:0];
				end
				mbpf_pkg::CFG_PATTERN_LENGTH: begin
					pat_len_q <= cfg.data[LEN_W-1:0];
				end
				mbpf_pkg::CFG_OCCURRENCE_INDEX: begin
					occ_q <= cfg.data[mbpf_pkg::OCC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// window and counters; a finished region ignores bytes until the next first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= 8'd0;
			end
			seen_q    <= '0;
			matches_q <= '0;
			done_q    <= 1'b0;
		end else if (accept && live) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= win_n[k];
			end
			seen_q    <= seen_n;
			matches_q <= matches_n;
			done_q    <= found_hit || data.last_byte;
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_found_q  <= skid_found_q;
				out_offset_q <= skid_offset_q;
			end else begin
				out_found_q  <= found_hit;
				out_offset_q <= res_offset;
			end
		end else if (res_valid) begin
			skid_found_q  <= found_hit;
			skid_offset_q <= res_offset;
		end
	end

endmodule

### rtl/core/mbpf_checker.sv
`timescale 1ns / 1ps

module mbpf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               out_found,
	input logic [mbpf_pkg::OUT_OFFSET_W-1:0]  out_offset
);

	// a result only follows a byte transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without a preceding byte transfer");

	// not-found carries a zero offset
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_found) |-> (out_offset == '0))
		else $error("not-found result with non-zero offset");

	// byte input is only held off behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_found) && $stable(out_offset)))
		else $error("stalled result changed");

endmodule

bind masked_byte_pattern_finder_core mbpf_checker u_mbpf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (data.valid),
	.in_ready   (data.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_found  (result.found),
	.out_offset (result.match_offset)
);

### bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for masked_byte_pattern_finder_core.
// Regions are streamed in bursts against a receiver that stalls on its own pattern.
// A small scoreboard class predicts the search result of every region from the
// accepted byte transfers and checks each result transfer, field by field.
module testbench;

	localparam int CFG_INDEX_W  = mbpf_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W   = mbpf_pkg::CFG_DATA_W;
	localparam int LEN_W        = mbpf_pkg::LEN_W;
	localparam int OCC_W        = mbpf_pkg::OCC_W;
	localparam int CARE_W       = mbpf_pkg::CARE_W;
	localparam int OUT_OFFSET_W = mbpf_pkg::OUT_OFFSET_W;
	localparam int PATTERN_W    = mbpf_pkg::PATTERN_W;

	localparam int CLK_PERIOD         = 12;
	localparam int RESET_CYCLES       = 10;
	localparam int CYCLE_LIMIT        = 1_000_000;
	localparam int RANDOM_BYTES       = 400;
	localparam int WINDOW_DEPTH       = 16;
	localparam int SETTLE_CYCLES      = 4;
	// register indexes the block does not decode
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LOW  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HIGH = 3'd7;
	// the wildcard character of the text form of such patterns
	localparam logic [7:0] WILDCARD_CHAR = 8'h3F;

	typedef enum int {RX_FLOW, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

	typedef struct packed {
		logic                    found;
		logic [OUT_OFFSET_W-1:0] match_offset;
	} search_result_t;

	class search_scoreboard;
		logic [PATTERN_W-1:0] pattern;   // byte i in bits 8i+7..8i
		logic [CARE_W-1:0]    care;
		logic [LEN_W-1:0]     length_reg;
		logic [OCC_W-1:0]     occurrence;
		logic [7:0]           window [WINDOW_DEPTH];   // entry 0 is the newest byte
		logic [31:0]          offset_count;
		logic [15:0]          hit_count;
		bit                   region_closed;
		search_result_t       pending_q[$];
		int mismatches, results_due, results_checked, found_checked;
		int regions_started, bytes_searched;

		function new();
			pattern = '0;
			care = '1;
			length_reg = 5'd1;
			occurrence = '0;
			foreach (window[k])
				window[k] = '0;
			offset_count = '0;
			hit_count = '0;
			region_closed = 1'b0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
			case (index)
				mbpf_pkg::CFG_PATTERN_LOW:      pattern[63:0] = value;
				mbpf_pkg::CFG_PATTERN_HIGH:     pattern[127:64] = value;
				mbpf_pkg::CFG_CARE_MASK:        care = value[CARE_W-1:0];
				mbpf_pkg::CFG_PATTERN_LENGTH:   length_reg = value[LEN_W-1:0];
				mbpf_pkg::CFG_OCCURRENCE_INDEX: occurrence = value[OCC_W-1:0];
				default: ;
			endcase
		endfunction

		function bit window_hit(int unsigned n);
			for (int unsigned i = 0; i < n; i++)
				if (care[i] && window[n - 1 - i] != pattern[8 * i +: 8])
					return 1'b0;
			return 1'b1;
		endfunction

		// One accepted byte transfer; queues the result it causes, if any.
		function void note_byte(logic [7:0] b, logic first, logic last);
			int unsigned    n;
			logic [15:0]    target;
			search_result_t r;
			n = (length_reg == 0) ? 1 : (length_reg > WINDOW_DEPTH) ? WINDOW_DEPTH : length_reg;
			target = (occurrence == 0) ? 16'd1 : occurrence;
			if (first) begin
				foreach (window[k])
					window[k] = '0;
				offset_count = '0;
				hit_count = '0;
				region_closed = 1'b0;
				regions_started++;
			end
			if (region_closed)
				return;
			bytes_searched++;
			for (int k = WINDOW_DEPTH - 1; k > 0; k--)
				window[k] = window[k - 1];
			window[0] = b;
			if (offset_count != '1)
				offset_count++;
			if (offset_count >= n && window_hit(n)) begin
				if (hit_count != 16'hFFFF)
					hit_count++;
				if (hit_count == target) begin
					region_closed = 1'b1;
					r.found = 1'b1;
					r.match_offset = offset_count - 32'(n);
					pending_q.push_back(r);
					results_due++;
					return;
				end
			end
			if (last) begin
				region_closed = 1'b1;
				r.found = 1'b0;
				r.match_offset = '0;
				pending_q.push_back(r);
				results_due++;
			end
		endfunction

		task report(string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(logic found, logic [OUT_OFFSET_W-1:0] match_offset);
			search_result_t want;
			results_checked++;
			if (pending_q.size() == 0) begin
				report($sformatf("result with nothing expected (found %0b offset %0d)",
					found, match_offset));
				return;
			end
			want = pending_q.pop_front();
			if (want.found)
				found_checked++;
			if (found !== want.found)
				report($sformatf("found %0b, expected %0b", found, want.found));
			if (match_offset !== want.match_offset)
				report($sformatf("match_offset %0d, expected %0d", match_offset,
					want.match_offset));
		endtask
	endclass

	logic clk;
	logic arst_n;

	mbpf_byte_if   data_ch();
	mbpf_result_if result_ch();
	mbpf_cfg_if    cfg_ch();

	masked_byte_pattern_finder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.data   (data_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	search_scoreboard sb = new();

	// Stimulus-side view of the current settings, used to plant matches
	logic [PATTERN_W-1:0] gen_pattern;
	logic [CARE_W-1:0]    gen_care;
	int                   gen_len;
	int                   burst_left;
	bit                   gaps_on;
	bit                   narrow_bytes;
	int                   random_items;
	int                   cfg_writes;
	int                   phases;
	int                   cycles;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Every transfer is observed here on the edge that makes it, using values from
	// before the edge, so ordering within the time step does not matter. Results are
	// checked before the byte of the same edge is noted; a result can only belong to
	// an earlier byte.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.found, result_ch.match_offset);
			if (data_ch.valid && data_ch.ready)
				sb.note_byte(data_ch.data_byte, data_ch.first_byte, data_ch.last_byte);
			if (cfg_ch.valid && cfg_ch.ready) begin
				sb.write_reg(cfg_ch.index, cfg_ch.data);
				cfg_writes++;
			end
		end
	end

	// Watchdog: ends the run as a failure once CYCLE_LIMIT is reached.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycles,
				sb.pending_q.size());
			$display("FAIL masked_byte_pattern_finder_core");
			$finish;
		end
	end

	// Receiver: stretches of free flow, coin-toss ready, sparse ready and full hold.
	initial begin
		rx_mode_t mode;
		int       span;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = rx_mode_t'($urandom_range(RX_FLOW, RX_HOLD));
			span = $urandom_range(4, 40);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					RX_FLOW:   result_ch.ready <= 1'b1;
					RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default:   result_ch.ready <= 1'b0;
				endcase
			end
		end
	end

	function automatic logic [7:0] alphabet_byte();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return WILDCARD_CHAR;
			default: return 8'h41;
		endcase
	endfunction

	// Filler for regions; the narrow form keeps bytes close to the pattern so that
	// partial and overlapping matches turn up often.
	function automatic logic [7:0] pick_byte(bit narrow);
		int slot;
		if (!narrow)
			return 8'($urandom);
		slot = $urandom_range(0, 15);
		if ($urandom_range(0, 1) == 0)
			return gen_pattern[8 * slot +: 8];
		return alphabet_byte();
	endfunction

	// One byte transfer. The sender works in bursts; valid is only lowered when a gap
	// follows, never lowered and raised in one step.
	task automatic put_byte(input logic [7:0] b, input logic first, input logic last);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				data_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		data_ch.valid      <= 1'b1;
		data_ch.data_byte  <= b;
		data_ch.first_byte <= first;
		data_ch.last_byte  <= last;
		do
			@(posedge clk);
		while (data_ch.ready !== 1'b1);
	endtask

	// Stop sending and wait until every expected result has been taken, then wait
	// SETTLE_CYCLES more so the block can finish bytes that cause no result.
	task automatic drain();
		data_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
	endtask

	// Writes every register (unused upper data bits random) plus an undecoded index.
	task automatic configure(input logic [PATTERN_W-1:0] pat, input logic [CARE_W-1:0] cm,
		input logic [LEN_W-1:0] len, input logic [OCC_W-1:0] occ);
		logic [CFG_DATA_W-1:0] junk;
		junk = {$urandom, $urandom};
		cfg_write(mbpf_pkg::CFG_PATTERN_LOW, pat[63:0]);
		cfg_write(mbpf_pkg::CFG_PATTERN_HIGH, pat[127:64]);
		cfg_write(mbpf_pkg::CFG_CARE_MASK, {junk[CFG_DATA_W-1:CARE_W], cm});
		cfg_write(mbpf_pkg::CFG_PATTERN_LENGTH, {junk[CFG_DATA_W-1:LEN_W], len});
		cfg_write(mbpf_pkg::CFG_OCCURRENCE_INDEX, {junk[CFG_DATA_W-1:OCC_W], occ});
		cfg_write(CFG_INDEX_W'($urandom_range(CFG_SPARE_LOW, CFG_SPARE_HIGH)),
			{$urandom, $urandom});
		cfg_ch.valid <= 1'b0;
		phases++;
		gen_pattern = pat;
		gen_care = cm;
		gen_len = (len == 0) ? 1 : (len > WINDOW_DEPTH) ? WINDOW_DEPTH : len;
	endtask

	// A region with up to three planted copies of the pattern (wildcards random).
	// Without first it continues whatever region is open; without last it is
	// abandoned by the next first.
	task automatic send_region(input int n_bytes, input bit with_first, input bit with_last,
		input bit counts);
		logic [7:0] body [$];
		int         pos;
		for (int i = 0; i < n_bytes; i++)
			body.push_back(pick_byte(narrow_bytes));
		repeat ($urandom_range(0, 3)) begin
			if (n_bytes >= gen_len) begin
				pos = $urandom_range(0, n_bytes - gen_len);
				for (int j = 0; j < gen_len; j++)
					body[pos + j] = gen_care[j] ? gen_pattern[8 * j +: 8] : 8'($urandom);
			end
		end
		for (int i = 0; i < n_bytes; i++)
			put_byte(body[i], with_first && i == 0, with_last && i == n_bytes - 1);
		if (counts)
			random_items += n_bytes;
	endtask

	initial begin
		logic [PATTERN_W-1:0] pat;
		logic [CARE_W-1:0]    cm;
		logic [LEN_W-1:0]     len;
		logic [OCC_W-1:0]     occ;
		int                   rlen;

		arst_n = 1'b0;
		data_ch.valid = 1'b0;
		data_ch.data_byte = '0;
		data_ch.first_byte = 1'b0;
		data_ch.last_byte = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		cycles = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		narrow_bytes = 1'b0;
		random_items = 0;
		cfg_writes = 0;
		phases = 0;
		gen_pattern = '0;
		gen_care = '1;
		gen_len = 1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: one-byte pattern 0x00, first occurrence.
		// One-byte regions (first and last together), found and not found, then a
		// match on the second byte, after which a byte with last set is ignored.
		put_byte(8'h00, 1'b1, 1'b1);
		put_byte(8'hFF, 1'b1, 1'b1);
		put_byte(8'hFF, 1'b1, 1'b0);
		put_byte(8'h00, 1'b0, 1'b0);
		put_byte(8'h00, 1'b0, 1'b1);
		drain();

		// Full-length pattern with wildcards at both ends, matched by exactly the
		// sixteen bytes of the region: the match on the last byte wins over not-found.
		pat = 128'hFF3F_0041_00FF_7E81_3F00_FF00_1234_00FF;
		configure(pat, 16'h7FFE, 5'd16, 16'd1);
		for (int i = 0; i < WINDOW_DEPTH; i++)
			put_byte(gen_care[i] ? pat[8 * i +: 8] : 8'($urandom), i == 0,
				i == WINDOW_DEPTH - 1);
		drain();

		// Length zero behaves as one; byte 0 is a wildcard, so the second match is
		// the second byte.
		configure(pat, 16'h7FFE, 5'd0, 16'd2);
		put_byte(8'hAB, 1'b1, 1'b0);
		put_byte(8'hCD, 1'b0, 1'b1);
		drain();

		// Random phases: fresh settings, then a handful of regions, mostly
		// well-formed, some continued, abandoned or followed by stray bytes.
		while (random_items < RANDOM_BYTES) begin
			case ($urandom_range(0, 3))
				0: pat = {$urandom, $urandom, $urandom, $urandom};
				1: for (int i = 0; i < WINDOW_DEPTH; i++)
					pat[8 * i +: 8] = alphabet_byte();
				2: pat = '0;
				default: pat = '1;
			endcase
			case ($urandom_range(0, 3))
				0: cm = '1;
				1: cm = '0;
				2: cm = CARE_W'($urandom);
				default: cm = ~(16'h1 << $urandom_range(0, 15));
			endcase
			// lengths out of range (zero, above sixteen) come round regularly
			if (phases % 7 == 1)
				len = '0;
			else if (phases % 7 == 2)
				len = LEN_W'($urandom_range(17, 31));
			else if ($urandom_range(0, 3) == 0)
				len = 5'd16;
			else
				len = LEN_W'($urandom_range(1, 8));
			case ($urandom_range(0, 9))
				0, 1, 2: occ = '0;
				3, 4:    occ = 16'd1;
				5:       occ = 16'd2;
				6:       occ = 16'd3;
				7:       occ = OCC_W'($urandom_range(4, 8));
				8:       occ = '1;
				default: occ = OCC_W'($urandom);
			endcase
			configure(pat, cm, len, occ);
			gaps_on = ($urandom_range(0, 3) != 0);
			narrow_bytes = 1'($urandom_range(0, 1));
			repeat ($urandom_range(2, 6)) begin
				rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
				case ($urandom_range(0, 9))
					0: send_region(rlen, 1'b0, 1'b1, 1'b0);
					1: send_region(rlen, 1'b1, 1'b0, 1'b1);
					2: begin
						send_region(rlen, 1'b1, 1'b1, 1'b1);
						// stray bytes after the region closed, last set at random
						repeat ($urandom_range(1, 3))
							put_byte(pick_byte(narrow_bytes), 1'b0, 1'($urandom_range(0, 1)));
					end
					default: send_region(rlen, 1'b1, 1'b1, 1'b1);
				endcase
			end
			drain();
		end

		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		if (sb.pending_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));

		$display("covered %0d regions, %0d bytes searched, %0d register writes over %0d settings",
			sb.regions_started, sb.bytes_searched, cfg_writes, phases);
		$display("checked %0d results (%0d found, %0d not found), %0d mismatches",
			sb.results_checked, sb.found_checked, sb.results_checked - sb.found_checked,
			sb.mismatches);
		if (sb.mismatches == 0)
			$display("PASS masked_byte_pattern_finder_core");
		else
			$display("FAIL masked_byte_pattern_finder_core");
		$finish;
	end

endmodule

### files.f
rtl/core/mbpf_pkg.sv
rtl/core/mbpf_ifs.sv
rtl/core/masked_byte_pattern_finder_core.sv
rtl/core/mbpf_checker.sv
bench/testbench.sv
